// ===== hw/rtl/olte_pkg.sv =====
// ----------------------------------------------------------------------------
// olte_pkg: shared types and codes of the ordered list table engine
// Command and status codes, the channel payloads and the cell operations.
// ----------------------------------------------------------------------------
package olte_pkg;

    localparam int CMD_W     = 3;
    localparam int POS_W     = 4;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;
    localparam int CAP_W     = 5;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET       = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    // What every cell of the chain does at a clock edge.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_WRITE  = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_REMOVE = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] entry_value;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  read_value;
        logic [COUNT_W-1:0]  count_after;
    } t_rsp;

endpackage

// ===== hw/rtl/olte_if.sv =====
// ----------------------------------------------------------------------------
// olte_if: item channels of the ordered list table engine
// Valid/ready channels for command items and response items.
// ----------------------------------------------------------------------------
interface olte_cmd_if import olte_pkg::*; ();
    logic valid;
    logic ready;
    t_cmd data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface olte_rsp_if import olte_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/olte_cell.sv =====
// ----------------------------------------------------------------------------
// olte_cell: one slot of the list
// Holds one entry and, on an insert or remove, takes the entry of its lower
// or upper neighbor so that the whole list shifts together.
// ----------------------------------------------------------------------------
module olte_cell
    import olte_pkg::*;
#(
    parameter int ENTRY_BITS = 32,
    parameter int IDX_W      = 4,
    parameter int CELL_IDX   = 0
) (
    input  logic                  i_clk,
    input  t_cell_op              i_op,
    input  logic [IDX_W-1:0]      i_addr,
    input  logic [ENTRY_BITS-1:0] i_value,
    input  logic [ENTRY_BITS-1:0] i_lower,
    input  logic [ENTRY_BITS-1:0] i_upper,
    output logic [ENTRY_BITS-1:0] o_entry
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [ENTRY_BITS-1:0] r_entry;
    logic [ENTRY_BITS-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        unique case (i_op)
            CELL_WRITE: begin
                if (MY_IDX == i_addr) begin
                    n_entry = i_value;
                end
            end
            CELL_INSERT: begin
                // Slots above the insert point move up by one.
                if (MY_IDX == i_addr) begin
                    n_entry = i_value;
                end else if (MY_IDX > i_addr) begin
                    n_entry = i_lower;
                end
            end
            CELL_REMOVE: begin
                // Slots at and above the removed one move down by one.
                if (MY_IDX >= i_addr) begin
                    n_entry = i_upper;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== hw/rtl/ordered_list_table_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_list_table_engine: bounded ordered list held in a chain of cells
// Executes push-back, set, get, pop-back, remove and insert commands on a
// list of up to DEPTH entries and answers each command with one response.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Handshake       Payload
//   i_cmd      in         valid / ready   command, position, entry_value
//   o_rsp      out        valid / ready   status, read_value, count_after
//   i_cfg_*    in         write enable    list_capacity (5 bits)
//
// The decode, the status checks and the shift of the whole cell chain
// all happen at the edge that accepts the item.
// The response sits in an output register; a new item is taken whenever that
// register is empty or is being emptied in the same cycle, so one item per
// cycle is sustained as long as the response side keeps taking items.
// Reset empties the list, drops any pending response and sets the capacity
// to sixteen. The entries themselves are not cleared; they are never read
// before they are written.
//
module ordered_list_table_engine
    import olte_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int ENTRY_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CAP_W-1:0]  i_cfg_wdata,
    olte_cmd_if.sink          i_cmd,
    olte_rsp_if.source        o_rsp
);

    // Widths that follow from the list depth. Comparisons between positions,
    // the count and the capacity are all done at CMP_W bits.
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CMP_W     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int VAL_BITS  = (ENTRY_BITS < VALUE_W) ? ENTRY_BITS : VALUE_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Configuration and list control state.
    logic [CAP_W-1:0]  r_cap;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    // Response output register.
    logic              r_rsp_valid;
    t_rsp              r_rsp;
    t_rsp              n_rsp;

    logic              w_accept;

    // Chain of cells.
    logic [ENTRY_BITS-1:0] w_entry [DEPTH];
    logic [ENTRY_BITS-1:0] w_lower [DEPTH];
    logic [ENTRY_BITS-1:0] w_upper [DEPTH];
    t_cell_op              w_op;
    logic [IDX_W-1:0]      w_addr;
    logic [ENTRY_BITS-1:0] w_value;

    // Decode helpers.
    logic [CMP_W-1:0]      w_pos;
    logic [CMP_W-1:0]      w_count;
    logic [CMP_W-1:0]      w_cap;
    logic [CMP_W-1:0]      w_cap_raw;
    logic [CMP_W-1:0]      w_count_new;
    logic [IDX_W-1:0]      w_rd_idx;
    logic [ENTRY_BITS-1:0] w_rd_entry;
    logic [VALUE_W-1:0]    w_rd_value;
    logic                  w_rd_en;
    logic [STATUS_W-1:0]   w_status;

    // A new command is taken when the response register is free, or is
    // handing its item over in this same cycle.
    assign i_cmd.ready = !r_rsp_valid || o_rsp.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    assign w_pos     = CMP_W'(i_cmd.data.position);
    assign w_count   = CMP_W'(r_count);
    assign w_cap_raw = CMP_W'(r_cap);
    // The usable capacity never exceeds the number of cells.
    assign w_cap     = (w_cap_raw > DEPTH_C) ? DEPTH_C : w_cap_raw;

    // Entry data is the low ENTRY_BITS of the command value, zero-extended
    // when the cells are wider than the port.
    always_comb begin
        w_value = '0;
        w_value[VAL_BITS-1:0] = i_cmd.data.entry_value[VAL_BITS-1:0];
    end

    // Command decoder: status, cell operation, target slot and new count.
    always_comb begin
        w_status    = ST_OK;
        w_op        = CELL_HOLD;
        w_addr      = w_pos[IDX_W-1:0];
        w_rd_idx    = w_pos[IDX_W-1:0];
        w_rd_en     = 1'b0;
        w_count_new = w_count;
        unique case (i_cmd.data.command)
            CMD_PUSH_BACK: begin
                w_addr = w_count[IDX_W-1:0];
                if (w_count >= w_cap) begin
                    w_status = ST_FULL;
                end else begin
                    w_op        = CELL_WRITE;
                    w_count_new = w_count + CMP_W'(1);
                end
            end
            CMD_SET: begin
                // Any slot below the capacity may be written, even above
                // the count; the count stays as it is.
                if (w_pos >= w_cap) begin
                    w_status = ST_RANGE;
                end else begin
                    w_op = CELL_WRITE;
                end
            end
            CMD_GET: begin
                if (w_pos >= w_count) begin
                    w_status = ST_RANGE;
                end else begin
                    w_rd_en = 1'b1;
                end
            end
            CMD_POP_BACK: begin
                w_rd_idx = IDX_W'(w_count - CMP_W'(1));
                if (w_count == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_rd_en     = 1'b1;
                    w_count_new = w_count - CMP_W'(1);
                end
            end
            CMD_REMOVE: begin
                if (w_pos >= w_count) begin
                    w_status = ST_RANGE;
                end else begin
                    w_op        = CELL_REMOVE;
                    w_count_new = w_count - CMP_W'(1);
                end
            end
            CMD_INSERT: begin
                // The position is checked before fullness, so an insert
                // can never append at the end of the list.
                if (w_pos >= w_count) begin
                    w_status = ST_RANGE;
                end else if (w_count >= w_cap) begin
                    w_status = ST_FULL;
                end else begin
                    w_op        = CELL_INSERT;
                    w_count_new = w_count + CMP_W'(1);
                end
            end
            default: begin
                // Unknown commands leave the list untouched.
                w_status = ST_RANGE;
            end
        endcase
        if (!w_accept) begin
            w_op        = CELL_HOLD;
            w_count_new = w_count;
        end
    end

    // Each cell sees its lower and upper neighbors; the ends of the chain
    // see zero, which only ever lands in slots beyond the count.
    generate
        for (genvar g = 0; g < DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_lower[g] = '0;
            end else begin : g_lower
                assign w_lower[g] = w_entry[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_upper[g] = '0;
            end else begin : g_upper
                assign w_upper[g] = w_entry[g+1];
            end

            olte_cell #(
                .ENTRY_BITS (ENTRY_BITS),
                .IDX_W      (IDX_W),
                .CELL_IDX   (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_op    (w_op),
                .i_addr  (w_addr),
                .i_value (w_value),
                .i_lower (w_lower[g]),
                .i_upper (w_upper[g]),
                .o_entry (w_entry[g])
            );
        end
    endgenerate

    // One read selection serves both get and pop-back.
    assign w_rd_entry = w_entry[w_rd_idx];

    always_comb begin
        w_rd_value = '0;
        if (w_rd_en) begin
            w_rd_value[VAL_BITS-1:0] = w_rd_entry[VAL_BITS-1:0];
        end
    end

    assign n_count = w_count_new[CNT_W-1:0];

    always_comb begin
        n_rsp.status      = w_status;
        n_rsp.read_value  = w_rd_value;
        n_rsp.count_after = w_count_new[COUNT_W-1:0];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_count <= n_count;
            if (w_accept) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Response payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the ordered list table engine
// A short scripted sequence walks the empty, full and out-of-range corners and
// the capacity register, then eight random phases under changing capacities
// and idle patterns. Every response is checked against a typed or model answer.
// ----------------------------------------------------------------------------
module tb_top;
    import olte_pkg::*;

    localparam int DEPTH           = 16;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int PHASE_COUNT     = 8;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int DRAIN_LIMIT     = 2000;
    localparam int REPORT_LIMIT    = 10;

    // Command codes the block does not define; both must answer out of range.
    localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

    // Idle percentages of the four traffic patterns.
    localparam int IDLE_NONE = 0;
    localparam int IDLE_HALF = 49;
    localparam int IDLE_BOTH = 31;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CAP_W-1:0] i_cfg_wdata;

    olte_cmd_if cmd_if ();
    olte_rsp_if rsp_if ();

    ordered_list_table_engine #(
        .DEPTH      (DEPTH),
        .ENTRY_BITS (VALUE_W)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd_if),
        .o_rsp       (rsp_if)
    );

    always #10 i_clk = ~i_clk;

    // The run is cut off here if the handshakes ever stop moving. The slowest
    // correct run stays far below this bound.
    initial begin
        #5_000_000;
        $display("ordered_list_table_engine: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Local list model. It mirrors the entries, the count and the capacity
    // register, and is advanced once for every command item the block takes.
    // ------------------------------------------------------------------------
    logic [VALUE_W-1:0] list_mem [DEPTH];
    logic [COUNT_W-1:0] list_len;
    logic [CAP_W-1:0]   list_cap;

    // Responses still owed by the block, oldest first.
    t_rsp answer_q [$];

    int mismatches = 0;

    // Traffic knobs, changed between phases by the stimulus process.
    int sender_idle_pct = IDLE_NONE;
    int rsp_stall_pct   = IDLE_NONE;
    bit hold_off_req    = 1'b0;

    // The capacity in use is the register clamped to the depth; zero stays
    // zero, so nothing can be pushed, inserted or set.
    function automatic int usable_capacity();
        return (list_cap > DEPTH) ? DEPTH : int'(list_cap);
    endfunction

    function automatic t_rsp list_apply_command(t_cmd c);
        t_rsp r;
        int   eff_cap;
        int   p;
        int   n;
        int   i;
        eff_cap       = usable_capacity();
        p             = c.position;
        n             = list_len;
        r.status      = ST_OK;
        r.read_value  = '0;
        case (c.command)
            CMD_PUSH_BACK: begin
                // Full means count at or above capacity, so a lowered
                // capacity blocks pushes even with the old entries kept.
                if (n >= eff_cap) begin
                    r.status = ST_FULL;
                end else begin
                    list_mem[n] = c.entry_value;
                    list_len    = list_len + 1'b1;
                end
            end
            CMD_SET: begin
                // Any slot below the capacity may be written, even past
                // the count; the count itself stays.
                if (p >= eff_cap) begin
                    r.status = ST_RANGE;
                end else begin
                    list_mem[p] = c.entry_value;
                end
            end
            CMD_GET: begin
                if (p >= n) begin
                    r.status = ST_RANGE;
                end else begin
                    r.read_value = list_mem[p];
                end
            end
            CMD_POP_BACK: begin
                if (n == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    list_len     = list_len - 1'b1;
                    r.read_value = list_mem[n-1];
                end
            end
            CMD_REMOVE: begin
                if (p >= n) begin
                    r.status = ST_RANGE;
                end else begin
                    for (i = p; i + 1 < n; i++) begin
                        list_mem[i] = list_mem[i+1];
                    end
                    list_len = list_len - 1'b1;
                end
            end
            CMD_INSERT: begin
                // The index is checked before fullness, and an insert can
                // never land at the end of the list.
                if (p >= n) begin
                    r.status = ST_RANGE;
                end else if (n >= eff_cap) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = n; i > p; i--) begin
                        list_mem[i] = list_mem[i-1];
                    end
                    list_mem[p] = c.entry_value;
                    list_len    = list_len + 1'b1;
                end
            end
            default: begin
                r.status = ST_RANGE;
            end
        endcase
        r.count_after = list_len;
        return r;
    endfunction

    function automatic void note_mismatch(string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: %s", $realtime, what);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Response side. The ready pattern follows the current stall percentage,
    // except during a hold-off, when ready stays low for a counted stretch
    // so that the output register fills and the block stops taking items.
    // ------------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
            end
        end
    end

    // Every response item taken at an edge is checked against the oldest
    // owed answer. Values read here are those that held at the edge.
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (answer_q.size() == 0) begin
                note_mismatch($sformatf("response with nothing owed: status %0d read %h count %0d",
                                        rsp_if.data.status, rsp_if.data.read_value,
                                        rsp_if.data.count_after));
            end else begin
                want = answer_q.pop_front();
                if (rsp_if.data.status !== want.status) begin
                    note_mismatch($sformatf("status: expected %0d, got %0d",
                                            want.status, rsp_if.data.status));
                end
                if (rsp_if.data.read_value !== want.read_value) begin
                    note_mismatch($sformatf("read_value: expected %h, got %h",
                                            want.read_value, rsp_if.data.read_value));
                end
                if (rsp_if.data.count_after !== want.count_after) begin
                    note_mismatch($sformatf("count_after: expected %0d, got %0d",
                                            want.count_after, rsp_if.data.count_after));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command side.
    // ------------------------------------------------------------------------

    // Offers one item and returns right after the edge that took it. The
    // valid line is left high, so back-to-back items follow without a gap.
    // A typed answer replaces the model's answer in the queue, but the model
    // still advances so that later rows stay in step.
    task automatic drive_command(input t_cmd c, input bit typed, input t_rsp want);
        t_rsp got;
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= c;
        do begin
            @(posedge i_clk);
        end while (!cmd_if.ready);
        got = list_apply_command(c);
        answer_q.push_back(typed ? want : got);
    endtask

    task automatic wait_for_answers();
        int waited;
        waited = 0;
        while (answer_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    // The capacity is only changed with the list idle: the offer is
    // withdrawn and every owed response is collected before the write.
    task automatic quiesce_and_configure(input logic [CAP_W-1:0] cap);
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        wait_for_answers();
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        list_cap  = cap;
    endtask

    // Random commands, shaped by the model's state so that most positions
    // hit live entries. Growing stretches push and insert more than they
    // take away, shrinking stretches the reverse, so the list keeps
    // swinging between empty and full. A few items are pure noise.
    function automatic t_cmd pick_random_command(bit growing);
        t_cmd c;
        int   roll;
        int   eff_cap;
        eff_cap       = usable_capacity();
        c.entry_value = $urandom;
        roll          = $urandom_range(99);
        if (roll < 3) begin
            c.entry_value = '0;
        end else if (roll < 6) begin
            c.entry_value = '1;
        end
        if ($urandom_range(99) < 5) begin
            c.command  = CMD_W'($urandom_range(7));
            c.position = POS_W'($urandom_range(15));
            return c;
        end
        roll = $urandom_range(99);
        if (growing) begin
            if      (roll < 30) c.command = CMD_PUSH_BACK;
            else if (roll < 50) c.command = CMD_INSERT;
            else if (roll < 65) c.command = CMD_SET;
            else if (roll < 80) c.command = CMD_GET;
            else if (roll < 90) c.command = CMD_POP_BACK;
            else                c.command = CMD_REMOVE;
        end else begin
            if      (roll < 10) c.command = CMD_PUSH_BACK;
            else if (roll < 20) c.command = CMD_INSERT;
            else if (roll < 35) c.command = CMD_SET;
            else if (roll < 50) c.command = CMD_GET;
            else if (roll < 75) c.command = CMD_POP_BACK;
            else                c.command = CMD_REMOVE;
        end
        if ($urandom_range(99) < 15) begin
            c.position = POS_W'($urandom_range(15));
        end else if (c.command == CMD_SET) begin
            c.position = (eff_cap > 0) ? POS_W'($urandom_range(eff_cap - 1))
                                       : POS_W'($urandom_range(15));
        end else begin
            c.position = (list_len > 0) ? POS_W'($urandom_range(list_len - 1))
                                        : POS_W'($urandom_range(15));
        end
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Scripted opening sequence. Rows either write the capacity or carry a
    // command; the answer is typed in where it is plain from the state.
    // ------------------------------------------------------------------------
    typedef struct {
        bit               is_cfg;
        logic [CAP_W-1:0] cap_value;
        t_cmd             cmd;
        bit               typed;
        t_rsp             want;
    } t_script_row;

    t_script_row script [$];

    function automatic void add_cfg(logic [CAP_W-1:0] cap);
        t_script_row row;
        row           = '{default: '0};
        row.is_cfg    = 1'b1;
        row.cap_value = cap;
        script.push_back(row);
    endfunction

    function automatic void add_cmd(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                    logic [VALUE_W-1:0] val);
        t_script_row row;
        row     = '{default: '0};
        row.cmd = '{command: cmd, position: pos, entry_value: val};
        script.push_back(row);
    endfunction

    function automatic void add_typed(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                      logic [VALUE_W-1:0] val, logic [STATUS_W-1:0] st,
                                      logic [VALUE_W-1:0] rd, logic [COUNT_W-1:0] cnt);
        t_script_row row;
        row       = '{default: '0};
        row.cmd   = '{command: cmd, position: pos, entry_value: val};
        row.typed = 1'b1;
        row.want  = '{status: st, read_value: rd, count_after: cnt};
        script.push_back(row);
    endfunction

    initial begin
        int               k;
        int               ph;
        t_rsp             no_answer;
        logic [CAP_W-1:0] phase_caps [PHASE_COUNT];

        no_answer = '0;

        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= '0;
        cmd_if.valid <= 1'b0;
        cmd_if.data  <= '0;

        for (k = 0; k < DEPTH; k++) begin
            list_mem[k] = '0;
        end
        list_len = '0;
        list_cap = CAP_W'(16);

        // Empty list: every reading or shifting command is refused, an
        // insert included, and undefined command codes answer out of range.
        add_typed(CMD_POP_BACK,  4'd0,  32'h0000_0000, ST_EMPTY, 32'h0, 5'd0);
        add_typed(CMD_GET,       4'd0,  32'h0000_0000, ST_RANGE, 32'h0, 5'd0);
        add_typed(CMD_REMOVE,    4'd3,  32'h0000_0000, ST_RANGE, 32'h0, 5'd0);
        add_typed(CMD_INSERT,    4'd0,  32'hDEAD_BEEF, ST_RANGE, 32'h0, 5'd0);
        add_typed(CMD_UNUSED_6,  4'd0,  32'h0000_0000, ST_RANGE, 32'h0, 5'd0);
        add_typed(CMD_UNUSED_7,  4'd15, 32'hFFFF_FFFF, ST_RANGE, 32'h0, 5'd0);
        // Extreme values through push and get.
        add_typed(CMD_PUSH_BACK, 4'd0,  32'hFFFF_FFFF, ST_OK, 32'h0, 5'd1);
        add_typed(CMD_PUSH_BACK, 4'd0,  32'h0000_0000, ST_OK, 32'h0, 5'd2);
        add_typed(CMD_GET,       4'd0,  32'h0000_0000, ST_OK, 32'hFFFF_FFFF, 5'd2);
        // Shifting in both directions, and a set far above the count.
        add_cmd(CMD_INSERT, 4'd1,  32'hA5A5_A5A5);
        add_cmd(CMD_INSERT, 4'd0,  32'h5A5A_5A5A);
        add_cmd(CMD_SET,    4'd15, 32'h1234_5678);
        add_cmd(CMD_SET,    4'd1,  32'h0F0F_0F0F);
        add_cmd(CMD_REMOVE, 4'd0,  32'h0000_0000);
        add_cmd(CMD_REMOVE, 4'd2,  32'h0000_0000);
        add_typed(CMD_GET,    4'd15, 32'h0000_0000, ST_RANGE, 32'h0, 5'd2);
        add_typed(CMD_INSERT, 4'd2,  32'h7777_7777, ST_RANGE, 32'h0, 5'd2);
        // Capacity lowered to the count: full, with the index tested first.
        add_cfg(5'd2);
        add_typed(CMD_PUSH_BACK, 4'd0, 32'h1111_1111, ST_FULL,  32'h0, 5'd2);
        add_typed(CMD_INSERT,    4'd0, 32'h2222_2222, ST_FULL,  32'h0, 5'd2);
        add_typed(CMD_SET,       4'd2, 32'h3333_3333, ST_RANGE, 32'h0, 5'd2);
        // Capacity zero: entries already held can still be popped.
        add_cfg(5'd0);
        add_typed(CMD_SET,      4'd0, 32'h4444_4444, ST_RANGE, 32'h0, 5'd2);
        add_cmd(CMD_POP_BACK,   4'd0, 32'h0000_0000);
        add_cmd(CMD_POP_BACK,   4'd0, 32'h0000_0000);
        add_typed(CMD_POP_BACK, 4'd0, 32'h0000_0000, ST_EMPTY, 32'h0, 5'd0);
        // Register above the depth is clamped to the depth.
        add_cfg(5'd31);
        add_typed(CMD_PUSH_BACK, 4'd0, 32'h8000_0001, ST_OK, 32'h0, 5'd1);
        add_typed(CMD_REMOVE,    4'd0, 32'h0000_0000, ST_OK, 32'h0, 5'd0);

        phase_caps    = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd7, 5'd16, 5'd12, 5'd2};
        phase_caps[6] = CAP_W'($urandom_range(1, 16));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[k]) begin
            if (script[k].is_cfg) begin
                quiesce_and_configure(script[k].cap_value);
            end else begin
                drive_command(script[k].cmd, script[k].typed, script[k].want);
            end
        end

        // Random phases. The four traffic patterns rotate, and the first
        // phase of each round holds the response side off for a while with
        // commands still being offered.
        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            quiesce_and_configure(phase_caps[ph]);
            case (ph % 4)
                0: begin
                    sender_idle_pct = IDLE_NONE;
                    rsp_stall_pct   = IDLE_NONE;
                    hold_off_req    = 1'b1;
                end
                1: begin
                    sender_idle_pct = IDLE_HALF;
                    rsp_stall_pct   = IDLE_NONE;
                end
                2: begin
                    sender_idle_pct = IDLE_NONE;
                    rsp_stall_pct   = IDLE_HALF;
                end
                default: begin
                    sender_idle_pct = IDLE_BOTH;
                    rsp_stall_pct   = IDLE_BOTH;
                end
            endcase
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                drive_command(pick_random_command(((k / 40) % 2) == 0), 1'b0, no_answer);
            end
        end

        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        wait_for_answers();
        repeat (4) @(posedge i_clk);
        while (answer_q.size() != 0) begin
            void'(answer_q.pop_front());
            note_mismatch("response never arrived");
        end

        if (mismatches == 0) begin
            $display("ordered_list_table_engine: match");
        end else begin
            $display("ordered_list_table_engine: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/olte_pkg.sv
hw/rtl/olte_if.sv
hw/rtl/olte_cell.sv
hw/rtl/ordered_list_table_engine.sv
tb/sv/tb_top.sv
